FILE: design/aesp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aesp_pkg
// Shared types and constants for the console escape sequence parser.
// ----------------------------------------------------------------------------
package aesp_pkg;

  typedef enum logic [3:0] {
    CMD_CHAR         = 4'd0,
    CMD_SET_CURSOR   = 4'd1,
    CMD_RIGHT        = 4'd2,
    CMD_CLEAR_SCREEN = 4'd3,
    CMD_CLEAR_BELOW  = 4'd4,
    CMD_CLEAR_EOL    = 4'd5,
    CMD_SCROLL_UP    = 4'd6,
    CMD_SCROLL_DOWN  = 4'd7,
    CMD_UPDATE       = 4'd8
  } cmd_t;

  // arguments travel pre-clipped to 0..65536
  localparam int ARG_W = 17;
  localparam logic [ARG_W-1:0] ARG_SAT = 17'h10000;

  localparam int PEND_DEPTH = 16;
  localparam int PEND_AW    = 4;
  localparam int CNT_W      = 5;
  localparam int TOTAL_W    = 6;
  localparam logic [TOTAL_W-1:0] RES_MAX = 6'd16;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;

  localparam int IN_DATA_W    = 8;
  localparam int OUT_DATA_W   = 48;
  localparam int OUT_USER_W   = 4;
  localparam int OUT_BOLD_BIT = 40;

  typedef struct packed {
    cmd_t             cmd;
    logic [7:0]       ch;
    logic             bold;
    logic             last;
    logic [ARG_W-1:0] arg_a;
    logic [ARG_W-1:0] arg_b;
  } entry_t;

endpackage
`default_nettype wire

FILE: design/ansi_escape_sequence_parser_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ansi_escape_sequence_parser_unit
// Console output byte stream to display command words.
//
// Input channel s_*: one console byte per word, tlast on the final byte of
// a write. Output channel m_*: one display command per word; tuser holds
// the command code, tlast marks the final command caused by an input byte.
// A plain byte is accepted every cycle while s_tready is high; its command
// passes the queue and output register. A broken escape sequence, or the end
// of a write, holds s_tready low as the front end queues one command per cycle
// if the queue has room: the replayed bytes (up to 13 with five-digit numbers),
// the byte itself and the cursor update, capped at 16 commands per byte. The
// four-entry queue lets input flow while the receiver stalls, until the queue
// fills. Reset clears the parse state, bold flag, queue and output valid; the
// pending byte store is not cleared, entries are read only once written.
// ----------------------------------------------------------------------------
module ansi_escape_sequence_parser_unit import aesp_pkg::*; #(
  parameter int MAX_DIGITS   = 5,
  parameter int NUMBER_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // [7:0] byte_in
  input  logic                  s_tlast,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // [15:0] row_arg, [31:16] col_arg,
                                           // [39:32] char_out, [40] bold_out
  output logic [OUT_USER_W-1:0] m_tuser,   // [3:0] command
  output logic                  m_tlast
);

  logic   q_push;
  logic   q_full;
  logic   q_pop;
  logic   q_empty;
  entry_t q_wr_entry;
  entry_t q_rd_entry;

  aesp_front #(
    .MAX_DIGITS   (MAX_DIGITS),
    .NUMBER_WIDTH (NUMBER_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .q_push   (q_push),
    .q_entry  (q_wr_entry),
    .q_full   (q_full)
  );

  aesp_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .wr_entry (q_wr_entry),
    .full     (q_full),
    .pop      (q_pop),
    .rd_entry (q_rd_entry),
    .empty    (q_empty)
  );

  aesp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .q_entry  (q_rd_entry),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("command queue written while full");

  a_update_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == CMD_UPDATE) |-> m_tlast)
    else $error("cursor update not last of its byte");

  a_bold_char_only: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != CMD_CHAR) |-> !m_tdata[OUT_BOLD_BIT])
    else $error("bold set on non-character command");

endmodule
`default_nettype wire

FILE: design/aesp_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aesp_fifo
// Short command queue between the parser front end and the output stage.
// ----------------------------------------------------------------------------
module aesp_fifo import aesp_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t wr_entry,
  output logic   full,
  input  logic   pop,
  output entry_t rd_entry,
  output logic   empty
);

  entry_t          mem [Q_DEPTH];
  logic [Q_AW-1:0] wp;
  logic [Q_AW-1:0] rp;
  logic [Q_AW:0]   count;

  assign full     = (count == (Q_AW+1)'(Q_DEPTH));
  assign empty    = (count == '0);
  assign rd_entry = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wp <= wp + Q_AW'(1);
      end
      if (pop) begin
        rp <= rp + Q_AW'(1);
      end
      if (push && !pop) begin
        count <= count + (Q_AW+1)'(1);
      end else if (!push && pop) begin
        count <= count - (Q_AW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= wr_entry;
    end
  end

endmodule
`default_nettype wire

FILE: design/aesp_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aesp_front
// Byte classifier: escape sequence grammar, pending byte store, bold flag
// and the sequencer that queues replayed bytes and the cursor update.
// ----------------------------------------------------------------------------
module aesp_front import aesp_pkg::*; #(
  parameter int MAX_DIGITS   = 5,
  parameter int NUMBER_WIDTH = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,
  input  logic       s_tlast,
  output logic       q_push,
  output entry_t     q_entry,
  input  logic       q_full
);

  localparam int DW = $clog2(MAX_DIGITS + 1);
  localparam logic [NUMBER_WIDTH-1:0] NUM_MAX = '1;

  localparam logic [7:0] B_ESC = 8'h1B;
  localparam logic [7:0] B_SO  = 8'h0E;
  localparam logic [7:0] B_SI  = 8'h0F;
  localparam logic [7:0] B_LBR = 8'h5B;
  localparam logic [7:0] B_EQ  = 8'h3D;
  localparam logic [7:0] B_GT  = 8'h3E;
  localparam logic [7:0] B_QM  = 8'h3F;
  localparam logic [7:0] B_ONE = 8'h31;
  localparam logic [7:0] B_SC  = 8'h3B;
  localparam logic [7:0] B_UC  = 8'h43;
  localparam logic [7:0] B_UD  = 8'h44;
  localparam logic [7:0] B_UH  = 8'h48;
  localparam logic [7:0] B_UJ  = 8'h4A;
  localparam logic [7:0] B_UK  = 8'h4B;
  localparam logic [7:0] B_UM  = 8'h4D;
  localparam logic [7:0] B_LL  = 8'h6C;
  localparam logic [7:0] B_LM  = 8'h6D;
  localparam logic [7:0] B_LR  = 8'h72;
  localparam logic [7:0] B_D0  = 8'h30;
  localparam logic [7:0] B_D9  = 8'h39;

  typedef enum logic [2:0] {
    PH_IDLE, PH_ESC, PH_CSI, PH_QM, PH_QM1, PH_NUM1, PH_SEMI, PH_NUM2
  } phase_t;

  typedef enum logic [2:0] {
    SQ_IDLE, SQ_REP1, SQ_MAIN, SQ_REP2, SQ_UPD
  } seq_t;

  function automatic logic [NUMBER_WIDTH-1:0] accum(
    input logic [NUMBER_WIDTH-1:0] v,
    input logic [7:0]              b
  );
    logic [NUMBER_WIDTH+3:0] t;
    t = ({4'd0, v} << 3) + ({4'd0, v} << 1) + (NUMBER_WIDTH+4)'(b[3:0]);
    if (t > {4'd0, NUM_MAX}) begin
      accum = NUM_MAX;
    end else begin
      accum = t[NUMBER_WIDTH-1:0];
    end
  endfunction

  function automatic logic [ARG_W-1:0] clip(input logic [NUMBER_WIDTH-1:0] v);
    logic [NUMBER_WIDTH+ARG_W-1:0] w;
    w = {{ARG_W{1'b0}}, v};
    if (w > {{NUMBER_WIDTH{1'b0}}, ARG_SAT}) begin
      clip = ARG_SAT;
    end else begin
      clip = w[ARG_W-1:0];
    end
  endfunction

  function automatic seq_t next_stage(
    input seq_t s,
    input logic has_main,
    input logic has_rep2,
    input logic has_upd
  );
    seq_t r;
    r = SQ_IDLE;
    case (s)
      SQ_REP1: begin
        if (has_main) r = SQ_MAIN;
        else if (has_rep2) r = SQ_REP2;
        else if (has_upd) r = SQ_UPD;
      end
      SQ_MAIN: begin
        if (has_rep2) r = SQ_REP2;
        else if (has_upd) r = SQ_UPD;
      end
      SQ_REP2: begin
        if (has_upd) r = SQ_UPD;
      end
      default: r = SQ_IDLE;
    endcase
    return r;
  endfunction

  // parser state
  phase_t                  ph;
  logic [NUMBER_WIDTH-1:0] num1;
  logic [NUMBER_WIDTH-1:0] num2;
  logic [DW-1:0]           dcnt;
  logic [CNT_W-1:0]        cnt;
  logic                    bold;
  logic [7:0]              pend [PEND_DEPTH];

  // sequencer state
  seq_t               sq;
  logic [PEND_AW-1:0] idx;
  logic [CNT_W-1:0]   left;
  logic [CNT_W-1:0]   sv_n1;
  logic [CNT_W-1:0]   sv_n2;
  logic               sv_main;
  logic               sv_upd;
  entry_t             sv_ent;

  // classification
  phase_t                  ph_next;
  logic [NUMBER_WIDTH-1:0] num1_next;
  logic [NUMBER_WIDTH-1:0] num2_next;
  logic [DW-1:0]           dcnt_next;
  logic [CNT_W-1:0]        cnt_next;
  logic                    bold_next;
  logic                    fail;
  logic                    idle_h;
  logic                    clr;
  logic                    push_b;
  logic                    wr_en;
  logic [PEND_AW-1:0]      wr_addr;
  logic                    m_en;
  entry_t                  m_ent;
  logic                    is_dig;
  logic                    dig_ok;

  logic [CNT_W-1:0]   n1;
  logic [CNT_W-1:0]   n2;
  logic [TOTAL_W-1:0] total;
  logic [CNT_W-1:0]   left_init;
  logic               acc;
  logic               slow;
  logic               fast_push;
  logic               sq_push;
  entry_t             sq_ent;
  logic [CNT_W-1:0]   rep_end;
  logic               rep_done;
  seq_t               first_stage;

  assign is_dig = s_tdata inside {[B_D0:B_D9]};
  assign dig_ok = is_dig && (dcnt < DW'(MAX_DIGITS));

  always_comb begin
    ph_next   = ph;
    num1_next = num1;
    num2_next = num2;
    dcnt_next = dcnt;
    cnt_next  = cnt;
    bold_next = bold;
    fail      = 1'b0;
    idle_h    = 1'b0;
    clr       = 1'b0;
    push_b    = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = cnt[PEND_AW-1:0];
    m_en      = 1'b0;
    m_ent     = '0;
    m_ent.last = 1'b1;
    case (ph)
      PH_ESC: begin
        if (s_tdata == B_LBR) begin
          push_b  = 1'b1;
          ph_next = PH_CSI;
        end else if (s_tdata inside {B_EQ, B_GT}) begin
          clr = 1'b1;
        end else if (s_tdata == B_UD) begin
          clr       = 1'b1;
          m_en      = 1'b1;
          m_ent.cmd = CMD_SCROLL_UP;
        end else if (s_tdata == B_UM) begin
          clr       = 1'b1;
          m_en      = 1'b1;
          m_ent.cmd = CMD_SCROLL_DOWN;
        end else begin
          fail = 1'b1;
        end
      end
      PH_CSI: begin
        if (s_tdata == B_UH) begin
          clr       = 1'b1;
          m_en      = 1'b1;
          m_ent.cmd = CMD_SET_CURSOR;
        end else if (s_tdata == B_UJ) begin
          clr       = 1'b1;
          m_en      = 1'b1;
          m_ent.cmd = CMD_CLEAR_BELOW;
        end else if (s_tdata == B_UK) begin
          clr       = 1'b1;
          m_en      = 1'b1;
          m_ent.cmd = CMD_CLEAR_EOL;
        end else if (s_tdata == B_LM) begin
          clr       = 1'b1;
          bold_next = 1'b0;
        end else if (s_tdata == B_QM) begin
          push_b  = 1'b1;
          ph_next = PH_QM;
        end else if (is_dig) begin
          push_b    = 1'b1;
          num1_next = accum('0, s_tdata);
          dcnt_next = DW'(1);
          ph_next   = PH_NUM1;
        end else begin
          fail = 1'b1;
        end
      end
      PH_QM: begin
        if (s_tdata == B_ONE) begin
          push_b  = 1'b1;
          ph_next = PH_QM1;
        end else begin
          fail = 1'b1;
        end
      end
      PH_QM1: begin
        if (s_tdata == B_LL) clr = 1'b1;
        else fail = 1'b1;
      end
      PH_NUM1: begin
        if (dig_ok) begin
          push_b    = 1'b1;
          num1_next = accum(num1, s_tdata);
          dcnt_next = dcnt + DW'(1);
        end else if (s_tdata == B_SC) begin
          push_b    = 1'b1;
          num2_next = '0;
          dcnt_next = '0;
          ph_next   = PH_SEMI;
        end else if (s_tdata == B_UC) begin
          clr         = 1'b1;
          m_en        = 1'b1;
          m_ent.cmd   = CMD_RIGHT;
          m_ent.arg_b = clip(num1);
        end else if (s_tdata == B_UJ) begin
          clr       = 1'b1;
          m_en      = 1'b1;
          m_ent.cmd = CMD_CLEAR_SCREEN;
        end else if (s_tdata == B_LM) begin
          clr = 1'b1;
          if (num1 == NUMBER_WIDTH'(1)) bold_next = 1'b1;
          else if (num1 == '0) bold_next = 1'b0;
        end else begin
          fail = 1'b1;
        end
      end
      PH_SEMI: begin
        if (is_dig) begin
          push_b    = 1'b1;
          num2_next = accum('0, s_tdata);
          dcnt_next = DW'(1);
          ph_next   = PH_NUM2;
        end else begin
          fail = 1'b1;
        end
      end
      PH_NUM2: begin
        if (dig_ok) begin
          push_b    = 1'b1;
          num2_next = accum(num2, s_tdata);
          dcnt_next = dcnt + DW'(1);
        end else if (s_tdata == B_UH) begin
          clr         = 1'b1;
          m_en        = 1'b1;
          m_ent.cmd   = CMD_SET_CURSOR;
          m_ent.arg_a = clip(num1);
          m_ent.arg_b = clip(num2);
        end else if (s_tdata == B_LR) begin
          clr = 1'b1;
        end else begin
          fail = 1'b1;
        end
      end
      default: idle_h = 1'b1;
    endcase

    if (push_b && (cnt < CNT_W'(PEND_DEPTH))) begin
      wr_en    = 1'b1;
      cnt_next = cnt + CNT_W'(1);
    end

    if (clr || fail || idle_h) begin
      ph_next   = PH_IDLE;
      cnt_next  = '0;
      num1_next = '0;
      num2_next = '0;
      dcnt_next = '0;
    end

    // broken sequence or idle: byte handled from a clean state
    if (fail || idle_h) begin
      if (s_tdata == B_ESC) begin
        ph_next  = PH_ESC;
        wr_en    = 1'b1;
        wr_addr  = '0;
        cnt_next = CNT_W'(1);
      end else if (!(s_tdata == B_SO || s_tdata == B_SI)) begin
        m_en       = 1'b1;
        m_ent.cmd  = CMD_CHAR;
        m_ent.ch   = s_tdata;
        m_ent.bold = bold;
      end
    end
  end

  assign n1    = fail ? cnt : '0;
  assign n2    = (s_tlast && (ph_next != PH_IDLE)) ? cnt_next : '0;
  assign total = {1'b0, n1} + TOTAL_W'(m_en) + {1'b0, n2} + TOTAL_W'(s_tlast);
  assign left_init = (total > RES_MAX) ? RES_MAX[CNT_W-1:0] : total[CNT_W-1:0];
  assign first_stage = (n1 != '0) ? SQ_REP1
                     : next_stage(SQ_REP1, m_en, n2 != '0, s_tlast);

  assign s_tready  = (sq == SQ_IDLE) && !q_full;
  assign acc       = s_tvalid && s_tready;
  assign slow      = fail || s_tlast;
  assign fast_push = acc && !slow && m_en;
  assign sq_push   = (sq != SQ_IDLE) && !q_full;

  assign rep_end  = (sq == SQ_REP1) ? sv_n1 : sv_n2;
  assign rep_done = (({1'b0, idx} + CNT_W'(1)) == rep_end);

  always_comb begin
    sq_ent = '0;
    case (sq)
      SQ_REP1, SQ_REP2: begin
        sq_ent.cmd  = CMD_CHAR;
        sq_ent.ch   = pend[idx];
        sq_ent.bold = bold;
      end
      SQ_MAIN: sq_ent = sv_ent;
      SQ_UPD:  sq_ent.cmd = CMD_UPDATE;
      default: sq_ent = '0;
    endcase
    sq_ent.last = (left == CNT_W'(1));
  end

  assign q_push  = fast_push || sq_push;
  assign q_entry = fast_push ? m_ent : sq_ent;

  always_ff @(posedge clk) begin
    if (rst) begin
      ph   <= PH_IDLE;
      num1 <= '0;
      num2 <= '0;
      dcnt <= '0;
      cnt  <= '0;
      bold <= 1'b0;
      sq   <= SQ_IDLE;
      idx  <= '0;
      left <= '0;
    end else if (acc) begin
      bold <= bold_next;
      if (s_tlast) begin
        ph   <= PH_IDLE;
        num1 <= '0;
        num2 <= '0;
        dcnt <= '0;
        cnt  <= '0;
      end else begin
        ph   <= ph_next;
        num1 <= num1_next;
        num2 <= num2_next;
        dcnt <= dcnt_next;
        cnt  <= cnt_next;
      end
      if (slow) begin
        sq      <= first_stage;
        idx     <= '0;
        left    <= left_init;
        sv_n1   <= n1;
        sv_n2   <= n2;
        sv_main <= m_en;
        sv_upd  <= s_tlast;
        sv_ent  <= m_ent;
      end
    end else if (sq_push) begin
      left <= left - CNT_W'(1);
      if (left == CNT_W'(1)) begin
        sq  <= SQ_IDLE;
        idx <= '0;
      end else if ((sq == SQ_REP1 || sq == SQ_REP2) && !rep_done) begin
        idx <= idx + PEND_AW'(1);
      end else begin
        sq  <= next_stage(sq, sv_main, sv_n2 != '0, sv_upd);
        idx <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc && wr_en) begin
      pend[wr_addr] <= s_tdata;
    end
  end

endmodule
`default_nettype wire

FILE: design/aesp_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aesp_back
// Output stage: takes queued commands, forms the result word, holds it
// until the receiver takes it.
// ----------------------------------------------------------------------------
module aesp_back import aesp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_empty,
  output logic                  q_pop,
  input  entry_t                q_entry,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic [OUT_USER_W-1:0] m_tuser,
  output logic                  m_tlast
);

  logic [15:0]      row;
  logic [15:0]      col;
  logic [7:0]       ch;
  logic             bd;
  logic [ARG_W-1:0] a_m1;
  logic [ARG_W-1:0] b_m1;

  assign a_m1  = q_entry.arg_a - ARG_W'(1);
  assign b_m1  = q_entry.arg_b - ARG_W'(1);
  assign q_pop = !q_empty && (!m_tvalid || m_tready);

  always_comb begin
    row = '0;
    col = '0;
    ch  = '0;
    bd  = 1'b0;
    case (q_entry.cmd)
      CMD_CHAR: begin
        ch = q_entry.ch;
        bd = q_entry.bold;
      end
      CMD_SET_CURSOR: begin
        // zero row or column counts as one
        row = (q_entry.arg_a == '0) ? '0 : a_m1[15:0];
        col = (q_entry.arg_b == '0) ? '0 : b_m1[15:0];
      end
      CMD_RIGHT: begin
        col = q_entry.arg_b[ARG_W-1] ? 16'hFFFF : q_entry.arg_b[15:0];
      end
      default: begin
        row = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (q_pop) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      m_tdata <= {(OUT_DATA_W-41)'(0), bd, ch, col, row};
      m_tuser <= q_entry.cmd;
      m_tlast <= q_entry.last;
    end
  end

endmodule
`default_nettype wire

FILE: tb/sv/tb_ansi_escape_sequence_parser_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_ansi_escape_sequence_parser_unit
// Streams console bytes into the escape sequence parser and checks every
// display command word against an in-bench model of the parser. The run has
// a short directed opening, then random well-formed, broken and overlong
// sequences mixed with plain and dropped bytes, under three idling profiles.
// ----------------------------------------------------------------------------
module tb_ansi_escape_sequence_parser_unit;
  import aesp_pkg::*;

  localparam logic [7:0] ESC = 8'h1B;
  localparam int NUM_SAT = 65535;
  localparam int DIGITS_MAX = 5;
  localparam int WORDS_PER_BYTE = 16;

  typedef enum int {
    PH_IDLE, PH_ESC, PH_CSI, PH_QMARK, PH_QONE, PH_NUM1, PH_SEMI, PH_NUM2
  } parse_phase_t;

  typedef enum int {
    SEQ_CUP, SEQ_MARGIN, SEQ_RIGHT, SEQ_CLEAR_N, SEQ_SGR_N, SEQ_HOME, SEQ_CLR_BELOW,
    SEQ_CLR_EOL, SEQ_SGR, SEQ_CURSOR_KEYS, SEQ_KEYPAD_APP, SEQ_KEYPAD_NUM,
    SEQ_REV_INDEX, SEQ_INDEX
  } seq_kind_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [15:0] row;
    logic [15:0] col;
    logic [7:0]  ch;
    logic        bold;
    logic        last;
  } display_cmd_t;

  typedef struct packed {
    logic [7:0] b;
    logic       eow;
  } console_byte_t;

  class aesp_scoreboard;
    display_cmd_t expected_cmds[$];
    display_cmd_t step_cmds[$];
    parse_phase_t phase;
    int first_num, second_num, digits;
    logic [7:0] held[16];
    int held_n;
    logic bold;
    int errors, bytes_noted, words_checked;

    function new();
      phase = PH_IDLE;
      first_num = 0;
      second_num = 0;
      digits = 0;
      held_n = 0;
      bold = 1'b0;
      errors = 0;
      bytes_noted = 0;
      words_checked = 0;
    endfunction

    function void emit(cmd_t c, int row, int col, logic [7:0] ch, logic bo);
      display_cmd_t w;
      w.cmd = c;
      w.row = 16'(row);
      w.col = 16'(col);
      w.ch = ch;
      w.bold = bo;
      w.last = 1'b0;
      if (step_cmds.size() < WORDS_PER_BYTE) step_cmds.push_back(w);
    endfunction

    function void clear_seq();
      phase = PH_IDLE;
      held_n = 0;
      first_num = 0;
      second_num = 0;
      digits = 0;
    endfunction

    function void hold(logic [7:0] b);
      if (held_n < 16) begin
        held[held_n] = b;
        held_n++;
      end
    endfunction

    function void replay();
      for (int i = 0; i < held_n; i++) emit(CMD_CHAR, 0, 0, held[i], bold);
      clear_seq();
    endfunction

    function void idle_byte(logic [7:0] b);
      if (b == ESC) begin
        clear_seq();
        phase = PH_ESC;
        hold(b);
      end else if (b != 8'h0E && b != 8'h0F) begin
        emit(CMD_CHAR, 0, 0, b, bold);
      end
    endfunction

    function void broken(logic [7:0] b);
      replay();
      idle_byte(b);
    endfunction

    function bit is_digit(logic [7:0] b);
      return b >= "0" && b <= "9";
    endfunction

    function int acc(int v, logic [7:0] b);
      int n;
      n = v * 10 + (int'(b) - 48);
      return n > NUM_SAT ? NUM_SAT : n;
    endfunction

    function void handle_byte(logic [7:0] b);
      int n;
      case (phase)
        PH_ESC: begin
          if (b == "[") begin
            hold(b);
            phase = PH_CSI;
          end else if (b == "=" || b == ">") clear_seq();
          else if (b == "D") begin
            clear_seq();
            emit(CMD_SCROLL_UP, 0, 0, 0, 0);
          end else if (b == "M") begin
            clear_seq();
            emit(CMD_SCROLL_DOWN, 0, 0, 0, 0);
          end else broken(b);
        end
        PH_CSI: begin
          if (b == "H") begin
            clear_seq();
            emit(CMD_SET_CURSOR, 0, 0, 0, 0);
          end else if (b == "J") begin
            clear_seq();
            emit(CMD_CLEAR_BELOW, 0, 0, 0, 0);
          end else if (b == "K") begin
            clear_seq();
            emit(CMD_CLEAR_EOL, 0, 0, 0, 0);
          end else if (b == "m") begin
            clear_seq();
            bold = 1'b0;
          end else if (b == "?") begin
            hold(b);
            phase = PH_QMARK;
          end else if (is_digit(b)) begin
            hold(b);
            first_num = acc(0, b);
            digits = 1;
            phase = PH_NUM1;
          end else broken(b);
        end
        PH_QMARK: begin
          if (b == "1") begin
            hold(b);
            phase = PH_QONE;
          end else broken(b);
        end
        PH_QONE: begin
          if (b == "l") clear_seq();
          else broken(b);
        end
        PH_NUM1: begin
          if (is_digit(b) && digits < DIGITS_MAX) begin
            hold(b);
            first_num = acc(first_num, b);
            digits++;
          end else if (b == ";") begin
            hold(b);
            second_num = 0;
            digits = 0;
            phase = PH_SEMI;
          end else if (b == "C") begin
            n = first_num;
            clear_seq();
            emit(CMD_RIGHT, 0, n, 0, 0);
          end else if (b == "J") begin
            clear_seq();
            emit(CMD_CLEAR_SCREEN, 0, 0, 0, 0);
          end else if (b == "m") begin
            n = first_num;
            clear_seq();
            if (n == 1) bold = 1'b1;
            else if (n == 0) bold = 1'b0;
          end else broken(b);
        end
        PH_SEMI: begin
          if (is_digit(b)) begin
            hold(b);
            second_num = acc(0, b);
            digits = 1;
            phase = PH_NUM2;
          end else broken(b);
        end
        PH_NUM2: begin
          if (is_digit(b) && digits < DIGITS_MAX) begin
            hold(b);
            second_num = acc(second_num, b);
            digits++;
          end else if (b == "H") begin
            // zero row or column counts as one
            emit(CMD_SET_CURSOR, (first_num == 0 ? 1 : first_num) - 1,
                 (second_num == 0 ? 1 : second_num) - 1, 0, 0);
            clear_seq();
          end else if (b == "r") clear_seq();
          else broken(b);
        end
        default: begin
          clear_seq();
          idle_byte(b);
        end
      endcase
    endfunction

    function void note_byte(logic [7:0] b, logic eow);
      step_cmds.delete();
      bytes_noted++;
      handle_byte(b);
      if (eow) begin
        if (phase != PH_IDLE) replay();
        emit(CMD_UPDATE, 0, 0, 0, 0);
      end
      if (step_cmds.size() > 0) step_cmds[step_cmds.size() - 1].last = 1'b1;
      foreach (step_cmds[i]) expected_cmds.push_back(step_cmds[i]);
    endfunction

    function void check_word(logic [OUT_USER_W-1:0] user, logic [OUT_DATA_W-1:0] data,
                             logic last);
      display_cmd_t e;
      words_checked++;
      if (expected_cmds.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected word: cmd %0d data %h last %0b", user, data, last);
        return;
      end
      e = expected_cmds.pop_front();
      if (e.cmd != user || e.row != data[15:0] || e.col != data[31:16] ||
          e.ch != data[39:32] || e.bold != data[OUT_BOLD_BIT] || e.last != last) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp cmd %0d row %0d col %0d ch %h bold %0b last %0b; got cmd %0d row %0d col %0d ch %h bold %0b last %0b",
                   e.cmd, e.row, e.col, e.ch, e.bold, e.last, user, data[15:0],
                   data[31:16], data[39:32], data[OUT_BOLD_BIT], last);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_DATA_W-1:0] s_tdata = '0;
  logic s_tlast = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [OUT_USER_W-1:0] m_tuser;
  logic m_tlast;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int eow_pct = 7;
  console_byte_t plan[$];
  aesp_scoreboard sb = new();

  ansi_escape_sequence_parser_unit uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_byte(s_tdata, s_tlast);
      if (m_tvalid && m_tready) sb.check_word(m_tuser, m_tdata, m_tlast);
    end
  end

  function automatic void add_byte(logic [7:0] b);
    console_byte_t c;
    c.b = b;
    c.eow = ($urandom_range(0, 99) < eow_pct);
    plan.push_back(c);
  endfunction

  function automatic void add_fixed(logic [7:0] b, logic eow);
    console_byte_t c;
    c.b = b;
    c.eow = eow;
    plan.push_back(c);
  endfunction

  function automatic void add_number(int n_digits);
    int mode;
    mode = $urandom_range(0, 9);
    if (n_digits > 0) begin
      for (int i = 0; i < n_digits; i++) add_byte(8'("0" + $urandom_range(0, 9)));
    end else if (mode == 0) add_byte("0");
    else if (mode == 1) begin
      add_byte("6"); add_byte("5"); add_byte("5"); add_byte("3"); add_byte("5");
    end else if (mode == 2) begin
      add_byte("6"); add_byte("5"); add_byte("5"); add_byte("3"); add_byte("6");
    end else if (mode == 3) begin
      for (int i = 0; i < 5; i++) add_byte("9");
    end else begin
      for (int i = $urandom_range(1, 5); i > 0; i--) add_byte(8'("0" + $urandom_range(0, 9)));
    end
  endfunction

  function automatic void add_sequence(seq_kind_t k);
    add_byte(ESC);
    case (k)
      SEQ_CUP, SEQ_MARGIN: begin
        add_byte("["); add_number(0); add_byte(";"); add_number(0);
        add_byte(k == SEQ_CUP ? "H" : "r");
      end
      SEQ_RIGHT: begin add_byte("["); add_number(0); add_byte("C"); end
      SEQ_CLEAR_N: begin add_byte("["); add_number(0); add_byte("J"); end
      SEQ_SGR_N: begin
        add_byte("[");
        case ($urandom_range(0, 2))
          0: add_byte("0");
          1: add_byte("1");
          default: add_number(0);
        endcase
        add_byte("m");
      end
      SEQ_HOME: begin add_byte("["); add_byte("H"); end
      SEQ_CLR_BELOW: begin add_byte("["); add_byte("J"); end
      SEQ_CLR_EOL: begin add_byte("["); add_byte("K"); end
      SEQ_SGR: begin add_byte("["); add_byte("m"); end
      SEQ_CURSOR_KEYS: begin add_byte("["); add_byte("?"); add_byte("1"); add_byte("l"); end
      SEQ_KEYPAD_APP: add_byte("=");
      SEQ_KEYPAD_NUM: add_byte(">");
      SEQ_REV_INDEX: add_byte("M");
      default: add_byte("D");
    endcase
  endfunction

  function automatic void add_random_chunk();
    int r, start, cut;
    r = $urandom_range(0, 99);
    if (r < 45) add_sequence(seq_kind_t'($urandom_range(0, 13)));
    else if (r < 60) begin
      start = plan.size();
      add_sequence(seq_kind_t'($urandom_range(0, 13)));
      cut = $urandom_range(1, plan.size() - start - 1);
      repeat (cut) void'(plan.pop_back());
      add_byte(8'($urandom_range(0, 255)));
    end else if (r < 68) begin
      // one digit too many
      add_byte(ESC); add_byte("[");
      if ($urandom_range(0, 1)) begin
        add_number(1); add_byte(";");
      end
      add_number(DIGITS_MAX + 1);
      add_byte($urandom_range(0, 1) ? "H" : "C");
    end else if (r < 85) add_byte(8'($urandom_range(8'h20, 8'h7E)));
    else if (r < 90) add_byte($urandom_range(0, 1) ? 8'h0E : 8'h0F);
    else add_byte(8'($urandom_range(0, 255)));
  endfunction

  task automatic send_plan();
    console_byte_t c;
    while (plan.size() != 0) begin
      c = plan.pop_front();
      while ($urandom_range(0, 99) < send_idle_pct) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
      end
      s_tvalid <= 1'b1;
      s_tdata <= c.b;
      s_tlast <= c.eow;
      do @(posedge clk); while (!s_tready);
    end
    s_tvalid <= 1'b0;
  endtask

  task automatic drain();
    // let the monitor note the last accepted byte first
    @(posedge clk);
    while (sb.expected_cmds.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed opening: byte extremes, dropped bytes, bold, zero cursor,
    // saturating count, index, flush of a pending sequence
    send_idle_pct = 24;
    recv_idle_pct = 65;
    add_fixed(8'h00, 1'b0); add_fixed(8'hFF, 1'b1);
    add_fixed(8'h0E, 1'b0); add_fixed(8'h0F, 1'b0);
    add_fixed(ESC, 1'b0); add_fixed("[", 1'b0); add_fixed("1", 1'b0); add_fixed("m", 1'b0);
    add_fixed("A", 1'b0);
    add_fixed(ESC, 1'b0); add_fixed("[", 1'b0); add_fixed("0", 1'b0);
    add_fixed(";", 1'b0); add_fixed("0", 1'b0); add_fixed("H", 1'b0);
    add_fixed(ESC, 1'b0); add_fixed("[", 1'b0);
    for (int i = 0; i < 5; i++) add_fixed("9", 1'b0);
    add_fixed("C", 1'b0);
    add_fixed(ESC, 1'b0); add_fixed("D", 1'b0);
    add_fixed(ESC, 1'b0); add_fixed("[", 1'b1);
    send_plan();
    // hold the sender until every word is back
    drain();

    for (int p = 0; p < 3; p++) begin
      send_idle_pct = (p == 0) ? 24 : (p == 1) ? 65 : 0;
      recv_idle_pct = (p == 0) ? 65 : (p == 1) ? 24 : 0;
      while (plan.size() < 80) add_random_chunk();
      send_plan();
      drain();
    end

    repeat (20) @(posedge clk);
    $display("covered %0d console bytes and %0d command words across three idling profiles",
             sb.bytes_noted, sb.words_checked);
    if (sb.errors == 0 && sb.expected_cmds.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("mismatches: %0d, outstanding: %0d", sb.errors, sb.expected_cmds.size());
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #600000;
    $display("timeout, outstanding words: %0d", sb.expected_cmds.size());
    $display("simulation failed");
    $finish;
  end

endmodule
`default_nettype wire
